[hw/rtl/ffms_pkg.sv]
// ----------------------------------------------------------------------------
// ffms_pkg
// Shared types, codes and reset values of the feeder fire-mode sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ffms_pkg;

	localparam int ANGLE_WIDTH_DEF = 32;

	localparam int FIELD_ANGLE_W = 32;
	localparam int SHOT_ANGLE_W  = 20;
	localparam int CFG_INDEX_W   = 3;
	localparam int CFG_DATA_W    = 20;

	// feed mode codes
	localparam logic [2:0] MODE_STOP    = 3'd0;
	localparam logic [2:0] MODE_SINGLE  = 3'd1;
	localparam logic [2:0] MODE_TRIPLE  = 3'd2;
	localparam logic [2:0] MODE_BURST   = 3'd3;
	localparam logic [2:0] MODE_REVERSE = 3'd4;

	// jam detector verdicts
	localparam logic [1:0] VERDICT_NORMAL    = 2'd0;
	localparam logic [1:0] VERDICT_SUSPECT   = 2'd1;
	localparam logic [1:0] VERDICT_CONFIRMED = 2'd2;
	localparam logic [1:0] VERDICT_HANDLING  = 2'd3;

	// feeder loop actions
	localparam logic [1:0] ACT_NONE       = 2'd0;
	localparam logic [1:0] ACT_SPEED_REF  = 2'd1;
	localparam logic [1:0] ACT_ANGLE_REF  = 2'd2;
	localparam logic [1:0] ACT_SPEED_ONLY = 2'd3;

	// projectile speed classes
	localparam logic [1:0] CLASS_LOW  = 2'd0;
	localparam logic [1:0] CLASS_MID  = 2'd1;
	localparam logic [1:0] CLASS_HIGH = 2'd2;

	// register indexes
	localparam logic [2:0] REG_SHOT_ANGLE      = 3'd0;
	localparam logic [2:0] REG_ANGLE_TOLERANCE = 3'd1;
	localparam logic [2:0] REG_BURST_GAIN      = 3'd2;
	localparam logic [2:0] REG_FRICTION_LOW    = 3'd3;
	localparam logic [2:0] REG_FRICTION_MID    = 3'd4;
	localparam logic [2:0] REG_FRICTION_HIGH   = 3'd5;

	// register reset values
	localparam logic [19:0] SHOT_ANGLE_RST      = 20'd25920;
	localparam logic [15:0] ANGLE_TOLERANCE_RST = 16'd80;
	localparam logic [15:0] BURST_GAIN_RST      = 16'd1620;
	localparam logic [15:0] FRICTION_LOW_RST    = 16'd4000;
	localparam logic [15:0] FRICTION_MID_RST    = 16'd6000;
	localparam logic [15:0] FRICTION_HIGH_RST   = 16'd8000;

	typedef struct packed {
		logic [19:0] shot_angle;
		logic [15:0] angle_tolerance;
		logic [15:0] burst_gain;
		logic [15:0] friction_speed_low;
		logic [15:0] friction_speed_mid;
		logic [15:0] friction_speed_high;
	} cfg_t;

	typedef struct packed {
		logic               fire_enabled;
		logic [2:0]         feed_mode;
		logic [7:0]         burst_rate;
		logic               friction_spin;
		logic [1:0]         speed_class;
		logic signed [31:0] feeder_angle;
		logic [1:0]         jam_verdict;
	} item_t;

	typedef struct packed {
		logic               motors_enabled;
		logic [1:0]         feeder_action;
		logic signed [31:0] feeder_reference;
		logic [15:0]        friction_reference;
		logic               detector_run;
		logic               detector_clear;
		logic               mode_fault;
	} result_t;

endpackage

`default_nettype wire

[hw/rtl/ffms_cfg.sv]
// ----------------------------------------------------------------------------
// ffms_cfg
// Configuration register file: shot angle, tolerance, burst gain, friction.
// ----------------------------------------------------------------------------
`default_nettype none

module ffms_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [ffms_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ffms_pkg::CFG_DATA_W-1:0]    cfg_data,
	output ffms_pkg::cfg_t                          cfg
);

	ffms_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shot_angle          <= ffms_pkg::SHOT_ANGLE_RST;
			cfg_q.angle_tolerance     <= ffms_pkg::ANGLE_TOLERANCE_RST;
			cfg_q.burst_gain          <= ffms_pkg::BURST_GAIN_RST;
			cfg_q.friction_speed_low  <= ffms_pkg::FRICTION_LOW_RST;
			cfg_q.friction_speed_mid  <= ffms_pkg::FRICTION_MID_RST;
			cfg_q.friction_speed_high <= ffms_pkg::FRICTION_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ffms_pkg::REG_SHOT_ANGLE:      cfg_q.shot_angle          <= cfg_data;
				ffms_pkg::REG_ANGLE_TOLERANCE: cfg_q.angle_tolerance     <= cfg_data[15:0];
				ffms_pkg::REG_BURST_GAIN:      cfg_q.burst_gain          <= cfg_data[15:0];
				ffms_pkg::REG_FRICTION_LOW:    cfg_q.friction_speed_low  <= cfg_data[15:0];
				ffms_pkg::REG_FRICTION_MID:    cfg_q.friction_speed_mid  <= cfg_data[15:0];
				ffms_pkg::REG_FRICTION_HIGH:   cfg_q.friction_speed_high <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ffms_core.sv]
// ----------------------------------------------------------------------------
// ffms_core
// Input register, sequencer state and the per-tick decision logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ffms_core #(
	parameter int ANGLE_WIDTH = ffms_pkg::ANGLE_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ffms_pkg::cfg_t       cfg,
	input  wire logic                 accept,
	input  wire ffms_pkg::item_t      item,
	input  wire logic                 advance,
	output logic                      valid_s1,
	output ffms_pkg::result_t         result
);

	localparam int CW = ((ANGLE_WIDTH > ffms_pkg::FIELD_ANGLE_W) ?
		ANGLE_WIDTH : ffms_pkg::FIELD_ANGLE_W) + 3;

	ffms_pkg::item_t        item_s1;

	logic [2:0]             prev_mode_q;
	logic                   jam_q;
	logic                   rearm_q;
	logic [ANGLE_WIDTH-1:0] target_q;
	logic                   fault_q;

	logic [2:0]             prev_mode_n;
	logic                   jam_n;
	logic                   rearm_n;
	logic [ANGLE_WIDTH-1:0] target_n;
	logic                   fault_n;

	logic [CW-1:0]          angle_x;
	logic [CW-1:0]          target_x;
	logic [CW-1:0]          shot_x;
	logic [CW-1:0]          shot_sum;
	logic [CW-1:0]          diff;
	logic [CW-1:0]          err_abs;
	logic [CW-1:0]          ref_x;
	logic                   latched;
	logic                   busy_raw;
	logic                   busy;
	logic                   detect;
	logic                   fire;
	logic [2:0]             mode;
	logic [23:0]            burst_speed;
	logic [15:0]            friction_ref;

	function automatic logic [ANGLE_WIDTH-1:0] sat_angle(input logic [CW-1:0] v);
		logic fits;
		fits = (&v[CW-1:ANGLE_WIDTH-1]) || !(|v[CW-1:ANGLE_WIDTH-1]);
		if (fits)
			return v[ANGLE_WIDTH-1:0];
		return v[CW-1] ? {1'b1, {(ANGLE_WIDTH-1){1'b0}}} : {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
	endfunction

	function automatic logic [31:0] sat_word(input logic [CW-1:0] v);
		logic fits;
		fits = (&v[CW-1:31]) || !(|v[CW-1:31]);
		if (fits)
			return v[31:0];
		return v[CW-1] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mode_q <= ffms_pkg::MODE_STOP;
			jam_q       <= 1'b0;
			rearm_q     <= 1'b0;
			target_q    <= '0;
			fault_q     <= 1'b0;
		end else if (valid_s1 && advance) begin
			prev_mode_q <= prev_mode_n;
			jam_q       <= jam_n;
			rearm_q     <= rearm_n;
			target_q    <= target_n;
			fault_q     <= fault_n;
		end
	end

	assign fire        = item_s1.fire_enabled;
	assign mode        = item_s1.feed_mode;
	assign angle_x     = {{(CW-32){item_s1.feeder_angle[31]}}, item_s1.feeder_angle};
	assign target_x    = {{(CW-ANGLE_WIDTH){target_q[ANGLE_WIDTH-1]}}, target_q};
	assign shot_x      = {{(CW-ffms_pkg::SHOT_ANGLE_W){1'b0}}, cfg.shot_angle};
	// triple shot advances three shot angles
	assign shot_sum    = angle_x + ((mode == ffms_pkg::MODE_TRIPLE) ?
		(shot_x + (shot_x << 1)) : shot_x);
	assign diff        = angle_x - target_x;
	assign err_abs     = diff[CW-1] ? (~diff + {{(CW-1){1'b0}}, 1'b1}) : diff;
	assign latched     = (prev_mode_q == ffms_pkg::MODE_SINGLE) ||
		(prev_mode_q == ffms_pkg::MODE_TRIPLE);
	assign busy_raw    = latched && (err_abs > {{(CW-16){1'b0}}, cfg.angle_tolerance});
	assign detect      = busy_raw || (mode == ffms_pkg::MODE_BURST) || jam_q;
	assign burst_speed = item_s1.burst_rate * cfg.burst_gain;

	always_comb begin
		prev_mode_n = prev_mode_q;
		jam_n       = jam_q;
		rearm_n     = rearm_q;
		target_n    = target_q;
		fault_n     = fault_q;
		busy        = busy_raw;
		ref_x       = '0;

		result.motors_enabled   = 1'b1;
		result.feeder_action    = ffms_pkg::ACT_NONE;
		result.detector_run     = 1'b0;
		result.detector_clear   = 1'b0;

		if (!fire) begin
			result.detector_clear = 1'b1;
			result.motors_enabled = 1'b0;
			jam_n                 = 1'b0;
			rearm_n               = 1'b0;
			prev_mode_n           = ffms_pkg::MODE_STOP;
		end

		if (fire && detect) begin
			result.detector_run = 1'b1;
			if (item_s1.jam_verdict == ffms_pkg::VERDICT_CONFIRMED ||
				item_s1.jam_verdict == ffms_pkg::VERDICT_HANDLING) begin
				jam_n   = 1'b1;
				rearm_n = 1'b1;
			end else if (jam_n && item_s1.jam_verdict == ffms_pkg::VERDICT_NORMAL) begin
				// jam cleared: hold position here and wait for a stop command
				jam_n                 = 1'b0;
				rearm_n               = 1'b1;
				prev_mode_n           = ffms_pkg::MODE_STOP;
				target_n              = sat_angle(angle_x);
				result.detector_clear = 1'b1;
				busy                  = 1'b0;
			end
		end else begin
			result.detector_clear = 1'b1;
			jam_n                 = 1'b0;
		end

		if (!jam_n && rearm_n && mode == ffms_pkg::MODE_STOP)
			rearm_n = 1'b0;

		if (fire && !jam_n && !rearm_n && !busy) begin
			unique case (mode)
				ffms_pkg::MODE_STOP: begin
					result.feeder_action = ffms_pkg::ACT_SPEED_REF;
				end
				ffms_pkg::MODE_SINGLE, ffms_pkg::MODE_TRIPLE: begin
					if (prev_mode_n != mode) begin
						target_n             = sat_angle(shot_sum);
						result.feeder_action = ffms_pkg::ACT_ANGLE_REF;
						ref_x                = {{(CW-ANGLE_WIDTH){target_n[ANGLE_WIDTH-1]}},
							target_n};
					end
				end
				ffms_pkg::MODE_BURST: begin
					result.feeder_action = ffms_pkg::ACT_SPEED_REF;
					ref_x                = {{(CW-24){1'b0}}, burst_speed};
				end
				ffms_pkg::MODE_REVERSE: begin
					result.feeder_action = ffms_pkg::ACT_SPEED_ONLY;
				end
				default: begin
					fault_n = 1'b1;
				end
			endcase
		end

		if (fire && !busy)
			prev_mode_n = mode;
		else if (!fire)
			prev_mode_n = ffms_pkg::MODE_STOP;

		result.feeder_reference   = sat_word(ref_x);
		result.friction_reference = friction_ref;
		result.mode_fault         = fault_n;
	end

	always_comb begin
		if (!item_s1.friction_spin) begin
			friction_ref = 16'd0;
		end else begin
			case (item_s1.speed_class)
				ffms_pkg::CLASS_MID:  friction_ref = cfg.friction_speed_mid;
				ffms_pkg::CLASS_HIGH: friction_ref = cfg.friction_speed_high;
				default:              friction_ref = cfg.friction_speed_low;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/feeder_fire_mode_sequencer.sv]
// ----------------------------------------------------------------------------
// feeder_fire_mode_sequencer
// Per-tick shooter control: feed mode sequencing, jam handling, friction speed.
// ----------------------------------------------------------------------------
// One request on the item channel is one control tick: firing state, feed
// mode, burst rate, friction settings, feeder angle and jam verdict. Each tick
// yields exactly one request on the result channel, in order.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. The item is held in an input register, the decision logic is
// combinational and the result lands in an output register, whose load
// raises result valid; while the result side does not stall, throughput is
// one tick per cycle.
// The sequencer state (last mode, jam and re-arm flags, angle target, fault)
// updates as a tick moves into the output register, ready for the next tick.
// While the result side stalls, the output register holds; an empty input
// register takes one more tick, then item_stall rises until the result drains.
// Configuration writes go through cfg_valid/cfg_ready (always ready); the user
// must make them only while no tick is in flight; the block does not enforce
// it. Reset clears all state, loads defaults and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module feeder_fire_mode_sequencer #(
	parameter int ANGLE_WIDTH = ffms_pkg::ANGLE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              item_valid,
	output logic                                   item_stall,
	input  wire logic                              fire_enabled,
	input  wire logic [2:0]                        feed_mode,
	input  wire logic [7:0]                        burst_rate,
	input  wire logic                              friction_spin,
	input  wire logic [1:0]                        speed_class,
	input  wire logic signed [31:0]                feeder_angle,
	input  wire logic [1:0]                        jam_verdict,

	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output logic                                   motors_enabled,
	output logic [1:0]                             feeder_action,
	output logic signed [31:0]                     feeder_reference,
	output logic [15:0]                            friction_reference,
	output logic                                   detector_run,
	output logic                                   detector_clear,
	output logic                                   mode_fault,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [ffms_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [ffms_pkg::CFG_DATA_W-1:0]   cfg_data
);

	ffms_pkg::cfg_t    cfg;
	ffms_pkg::item_t   item;
	ffms_pkg::result_t step_result;
	ffms_pkg::result_t result_q;
	logic              result_valid_q;
	logic              valid_s1;
	logic              advance;
	logic              accept;

	// output register free or being drained this cycle
	assign advance    = !result_valid_q || !result_stall;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	assign item.fire_enabled  = fire_enabled;
	assign item.feed_mode     = feed_mode;
	assign item.burst_rate    = burst_rate;
	assign item.friction_spin = friction_spin;
	assign item.speed_class   = speed_class;
	assign item.feeder_angle  = feeder_angle;
	assign item.jam_verdict   = jam_verdict;

	ffms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ffms_core #(
		.ANGLE_WIDTH (ANGLE_WIDTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.accept   (accept),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.result   (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= step_result;
		end
	end

	assign result_valid       = result_valid_q;
	assign motors_enabled     = result_q.motors_enabled;
	assign feeder_action      = result_q.feeder_action;
	assign feeder_reference   = result_q.feeder_reference;
	assign friction_reference = result_q.friction_reference;
	assign detector_run       = result_q.detector_run;
	assign detector_clear     = result_q.detector_clear;
	assign mode_fault         = result_q.mode_fault;

endmodule

`default_nettype wire
